// ===== sv/ntt_twiddle_table_entry_top_assert.svh =====
// Assertion macros used by the checker file
`ifndef NTT_TWIDDLE_TABLE_ENTRY_TOP_ASSERT_SVH
`define NTT_TWIDDLE_TABLE_ENTRY_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define NTE_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset
`define NTE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`endif

// ===== sv/nte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nte_pkg
// Shared constants, register indexes and types for the twiddle entry block.
// ----------------------------------------------------------------------------
package nte_pkg;
	localparam int unsigned WordW    = 64;
	localparam int unsigned IndexW   = 16;
	localparam int unsigned LogNW    = 5;
	localparam int unsigned MaxLogN  = 16;
	localparam int unsigned CntW     = 7;

	localparam logic [1:0] RegModulus = 2'd0;
	localparam logic [1:0] RegRoot    = 2'd1;
	localparam logic [1:0] RegLogN    = 2'd2;

	// operation codes for the shared serial arithmetic unit
	typedef enum logic [1:0] {
		OP_MUL   = 2'd0,
		OP_SHOUP = 2'd1,
		OP_RED   = 2'd2
	} nte_op_t;

	typedef struct packed {
		logic    start;
		nte_op_t op;
	} nte_cmd_t;
endpackage

// ===== sv/ntt_twiddle_table_entry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_twiddle_table_entry_top
// One bit-reversed NTT twiddle entry with Shoup constants, digit-serial.
// ----------------------------------------------------------------------------
// channel | handshake        | payload
// in      | in_valid/ready   | table_index
// out     | out_valid/ready  | six 64-bit values, index_bad
// cfg     | cfg_we           | cfg_index, cfg_data
// One item at a time through one bit-serial modular unit, which runs each
// multiply, reduction or Shoup quotient bit by bit. An entry runs up to
// 2*128 ladder steps on q-2 and 2*32 on the index, plus three reductions
// and three quotients.
// A bad index or modulus below two is offered the cycle after acceptance.
// Reset returns modulus 3, root 1, log_n 0. Output holds while stalled.
module ntt_twiddle_table_entry_top import nte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [WordW-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [IndexW-1:0] table_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WordW-1:0]  fwd_twiddle,
	output logic [WordW-1:0]  fwd_shoup,
	output logic [WordW-1:0]  inv_twiddle,
	output logic [WordW-1:0]  inv_shoup,
	output logic [WordW-1:0]  size_inverse,
	output logic [WordW-1:0]  size_inverse_shoup,
	output logic              index_bad
);
	localparam int unsigned RevIdxW = $clog2(IndexW);

	logic [WordW-1:0]  modulus_q, root_q;
	logic [LogNW-1:0]  log_n_q, ln;
	logic              busy_q, go;
	logic [IndexW-1:0] rev_d, rev_q;
	logic [WordW-1:0]  n_val, fw, fws, iw, iws, ni, nis;
	logic              fin;
	logic [IndexW:0]   n_wide;

	// hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 64'd3;
			root_q    <= 64'd1;
			log_n_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegModulus: modulus_q <= cfg_data;
				RegRoot:    root_q    <= cfg_data;
				RegLogN:    log_n_q   <= cfg_data[LogNW-1:0];
				default:    ;
			endcase
		end
	end

	assign ln     = (log_n_q > LogNW'(MaxLogN)) ? LogNW'(MaxLogN) : log_n_q;
	assign n_wide = (IndexW+1)'(1) << ln;
	assign n_val  = {{(WordW-IndexW-1){1'b0}}, n_wide};

	// bit reverse over the low ln bits
	always_comb begin
		rev_d = '0;
		for (int k = 0; k < IndexW; k++)
			if (LogNW'(k) < ln) rev_d[RevIdxW'(ln - LogNW'(k) - 1'b1)] = table_index[k];
	end

	// hold the reversed index for the whole entry
	always_ff @(posedge clk) begin
		if (go) rev_q <= rev_d;
	end

	logic bad, degen;
	assign bad   = {1'b0, table_index} >= n_wide;
	assign degen = modulus_q < 64'd2;
	assign in_ready = !busy_q && !out_valid;
	assign go = in_valid && in_ready && !bad && !degen;

	nte_seq u_seq (
		.clk(clk), .arst_n(arst_n), .go(go), .q(modulus_q), .root(root_q),
		.n_val(n_val), .rev(rev_q), .fin(fin),
		.fw(fw), .fws(fws), .iw(iw), .iws(iws), .ni(ni), .nis(nis)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (go) busy_q <= 1'b1;
			else if (in_valid && in_ready) out_valid <= 1'b1;
			if (fin) begin
				busy_q    <= 1'b0;
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && !go) begin
			index_bad <= bad;
			{fwd_twiddle, fwd_shoup, inv_twiddle} <= '0;
			{inv_shoup, size_inverse, size_inverse_shoup} <= '0;
		end else if (fin) begin
			index_bad <= 1'b0;
			fwd_twiddle <= fw; fwd_shoup <= fws;
			inv_twiddle <= iw; inv_shoup <= iws;
			size_inverse <= ni; size_inverse_shoup <= nis;
		end
	end
endmodule

// ===== sv/nte_serial_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nte_serial_alu
// Bit-serial modular multiply, Shoup quotient and reduction, one bit a cycle.
// ----------------------------------------------------------------------------
module nte_serial_alu import nte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  nte_cmd_t          cmd,
	input  logic [WordW-1:0]  a,
	input  logic [WordW-1:0]  b,
	input  logic [WordW-1:0]  q,
	output logic              busy,
	output logic              done,
	output logic [WordW-1:0]  res
);
	logic [WordW-1:0] r_q, b_q, a_q, quo_q;
	logic [CntW-1:0]  cnt_q;
	nte_op_t          op_q;
	logic             busy_q, done_q;
	logic [WordW:0]   dbl, dsub, acc, asub;
	logic [WordW-1:0] r1, r2;

	// double then conditionally add, each reduced by one subtract
	always_comb begin
		dbl  = {r_q, 1'b0};
		dsub = dbl - {1'b0, q};
		r1   = (dbl >= {1'b0, q}) ? dsub[WordW-1:0] : dbl[WordW-1:0];
		acc  = {1'b0, r1} + {1'b0, a_q};
		asub = acc - {1'b0, q};
		r2   = (acc >= {1'b0, q}) ? asub[WordW-1:0] : acc[WordW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(WordW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			a_q   <= a;
			b_q   <= b;
			quo_q <= '0;
			unique case (cmd.op)
				OP_SHOUP: r_q <= a;
				default:  r_q <= '0;
			endcase
		end else if (busy_q) begin
			b_q <= {b_q[WordW-2:0], 1'b0};
			unique case (op_q)
				OP_MUL:   r_q <= b_q[WordW-1] ? r2 : r1;
				OP_RED:   r_q <= b_q[WordW-1] ? r2 : r1;
				OP_SHOUP: begin
					r_q   <= r1;
					quo_q <= {quo_q[WordW-2:0], dbl >= {1'b0, q}};
				end
				default:  r_q <= r1;
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = (op_q == OP_SHOUP) ? quo_q : r_q;
endmodule

// ===== sv/nte_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nte_seq
// Sequencer: walks the exponentiations and Shoup steps for one table entry.
// ----------------------------------------------------------------------------
module nte_seq import nte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [WordW-1:0]  q,
	input  logic [WordW-1:0]  root,
	input  logic [WordW-1:0]  n_val,
	input  logic [IndexW-1:0] rev,
	output logic              fin,
	output logic [WordW-1:0]  fw,
	output logic [WordW-1:0]  fws,
	output logic [WordW-1:0]  iw,
	output logic [WordW-1:0]  iws,
	output logic [WordW-1:0]  ni,
	output logic [WordW-1:0]  nis
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_RED  = 8'b00000010,
		S_MUL  = 8'b00000100,
		S_SQR  = 8'b00001000,
		S_NEXT = 8'b00010000,
		S_SHP  = 8'b00100000,
		S_WAIT = 8'b01000000,
		S_FIN  = 8'b10000000
	} st_t;

	st_t              st_q;
	logic [1:0]       job_q;
	logic [WordW-1:0] base_q, acc_q, e_q;
	logic [WordW-1:0] rinv_q;
	logic [1:0]       shp_q;
	nte_cmd_t         cmd;
	logic [WordW-1:0] op_a, op_b, alu_res;
	logic             alu_busy, alu_done, issued_q;

	nte_serial_alu u_alu (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .a(op_a), .b(op_b), .q(q),
		.busy(alu_busy), .done(alu_done), .res(alu_res)
	);

	// job 0: root_inv, 1: fw, 2: iw, 3: ni
	always_comb begin
		cmd.start = 1'b0;
		cmd.op    = OP_MUL;
		op_a      = acc_q;
		op_b      = base_q;
		unique case (st_q)
			S_RED: begin
				cmd.start = !issued_q;
				cmd.op    = OP_RED;
				op_b      = (job_q == 2'd3) ? n_val : root;
				op_a      = 64'd1;
			end
			S_MUL: cmd.start = !issued_q;
			S_SQR: begin
				cmd.start = !issued_q;
				op_a      = base_q;
			end
			S_SHP: begin
				cmd.start = !issued_q;
				cmd.op    = OP_SHOUP;
				unique case (shp_q)
					2'd0:    op_a = fw;
					2'd1:    op_a = iw;
					default: op_a = ni;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			issued_q <= 1'b0;
			job_q    <= '0;
			shp_q    <= '0;
		end else begin
			if (cmd.start) issued_q <= 1'b1;
			unique case (st_q)
				S_IDLE: if (go) begin
					job_q <= 2'd0;
					st_q  <= S_RED;
				end
				S_RED: if (alu_done) begin
					issued_q <= 1'b0;
					st_q     <= S_NEXT;
				end
				S_MUL: if (alu_done) begin
					issued_q <= 1'b0;
					st_q     <= S_SQR;
				end
				S_SQR: if (alu_done) begin
					issued_q <= 1'b0;
					st_q     <= S_NEXT;
				end
				S_NEXT: begin
					if (e_q == '0) begin
						if (job_q == 2'd3) begin
							shp_q <= 2'd0;
							st_q  <= S_SHP;
						end else begin
							job_q <= job_q + 1'b1;
							st_q  <= (job_q == 2'd1) ? S_WAIT : S_RED;
						end
					end else st_q <= e_q[0] ? S_MUL : S_SQR;
				end
				S_WAIT: st_q <= S_NEXT;
				S_SHP: if (alu_done) begin
					issued_q <= 1'b0;
					if (shp_q == 2'd2) st_q <= S_FIN;
					else shp_q <= shp_q + 1'b1;
				end
				S_FIN: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// operands and results of the exponentiation ladder
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_RED: if (alu_done) begin
				base_q <= alu_res;
				acc_q  <= 64'd1;
				e_q    <= (job_q == 2'd1) ? {{(WordW-IndexW){1'b0}}, rev} : q - 64'd2;
			end
			S_MUL: if (alu_done) acc_q <= alu_res;
			S_SQR: if (alu_done) begin
				base_q <= alu_res;
				e_q    <= e_q >> 1;
			end
			S_NEXT: if (e_q == '0) begin
				unique case (job_q)
					2'd0: begin
						base_q <= acc_q;
					end
					2'd1: fw <= acc_q;
					2'd2: iw <= acc_q;
					default: ni <= acc_q;
				endcase
			end
			S_WAIT: begin
				base_q <= rinv_q;
				acc_q  <= 64'd1;
				e_q    <= {{(WordW-IndexW){1'b0}}, rev};
			end
			S_SHP: if (alu_done) begin
				unique case (shp_q)
					2'd0:    fws <= alu_res;
					2'd1:    iws <= alu_res;
					default: nis <= alu_res;
				endcase
			end
			default: ;
		endcase
	end

	// keep root_inv as the iw base: job 2 starts from S_WAIT after job 1
	always_ff @(posedge clk) begin
		if (st_q == S_NEXT && e_q == '0 && job_q == 2'd0) rinv_q <= acc_q;
	end

	assign fin = (st_q == S_FIN);
endmodule

// ===== sv/nte_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nte_checker
// Port-level checks for the twiddle entry block.
// ----------------------------------------------------------------------------
`include "ntt_twiddle_table_entry_top_assert.svh"
module nte_checker import nte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic index_bad,
	input logic [WordW-1:0] fwd_twiddle
);
	`NTE_ASSERT_IMPL(a_no_accept_full, clk, arst_n, out_valid, !in_ready)
	`NTE_ASSERT_IMPL(a_bad_zero, clk, arst_n, out_valid && index_bad, fwd_twiddle == '0)
	`NTE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(fwd_twiddle))
endmodule

bind ntt_twiddle_table_entry_top nte_checker u_nte_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .index_bad(index_bad),
	.fwd_twiddle(fwd_twiddle)
);

// ===== verif/tb_ntt_twiddle_table_entry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntt_twiddle_table_entry_top
// Drives table indexes under a range of modulus, root and size settings and
// checks each twiddle entry against values worked out with wide arithmetic.
// ----------------------------------------------------------------------------
module tb_ntt_twiddle_table_entry_top;
	import nte_pkg::*;

	localparam int unsigned StallLimit = 400000;
	localparam int unsigned HoldCycles = 300;

	typedef struct packed {
		logic [WordW-1:0] fwd_tw;
		logic [WordW-1:0] fwd_sh;
		logic [WordW-1:0] inv_tw;
		logic [WordW-1:0] inv_sh;
		logic [WordW-1:0] n_inv;
		logic [WordW-1:0] n_inv_sh;
		logic             bad;
	} entry_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [WordW-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [IndexW-1:0] table_index;
	logic              out_valid;
	logic              out_ready;
	logic [WordW-1:0]  fwd_twiddle;
	logic [WordW-1:0]  fwd_shoup;
	logic [WordW-1:0]  inv_twiddle;
	logic [WordW-1:0]  inv_shoup;
	logic [WordW-1:0]  size_inverse;
	logic [WordW-1:0]  size_inverse_shoup;
	logic              index_bad;

	// settings as last written
	logic [WordW-1:0] cur_q;
	logic [WordW-1:0] cur_root;
	logic [4:0]       cur_log_n;

	logic [IndexW-1:0] index_queue[$];
	entry_t            entry_queue[$];
	int                errors;
	int                in_gap;
	int                out_gap;
	int                hold_left;
	bit                hold_request;
	bit                no_idle;
	int unsigned       quiet_cycles;

	ntt_twiddle_table_entry_top u_dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [WordW-1:0] mul_mod(logic [WordW-1:0] a, logic [WordW-1:0] b,
			logic [WordW-1:0] q);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return WordW'(p % {64'd0, q});
	endfunction

	function automatic logic [WordW-1:0] pow_mod(logic [WordW-1:0] b, logic [WordW-1:0] e,
			logic [WordW-1:0] q);
		logic [WordW-1:0] r;
		logic [WordW-1:0] x;
		r = 64'd1;
		x = b % q;
		for (int k = 0; k < 64; k++) begin
			if (e[k])
				r = mul_mod(r, x, q);
			x = mul_mod(x, x, q);
		end
		return r;
	endfunction

	function automatic logic [WordW-1:0] shoup_of(logic [WordW-1:0] x, logic [WordW-1:0] q);
		logic [127:0] num;
		num = {x, 64'd0};
		return WordW'(num / {64'd0, q});
	endfunction

	// work out one table entry from the current settings
	function automatic entry_t twiddle_entry(logic [IndexW-1:0] idx);
		entry_t e;
		int unsigned ln;
		logic [16:0] n;
		logic [15:0] rev;
		logic [WordW-1:0] rinv;
		e = '0;
		ln = (cur_log_n > MaxLogN) ? MaxLogN : cur_log_n;
		n = 17'd1 << ln;
		if ({1'b0, idx} >= n) begin
			e.bad = 1'b1;
			return e;
		end
		if (cur_q < 2)
			return e;
		rev = '0;
		for (int k = 0; k < ln; k++)
			rev = {rev[14:0], idx[k]};
		rinv = pow_mod(cur_root, cur_q - 2, cur_q);
		e.fwd_tw = pow_mod(cur_root, {48'd0, rev}, cur_q);
		e.inv_tw = pow_mod(rinv, {48'd0, rev}, cur_q);
		e.n_inv = pow_mod({47'd0, n}, cur_q - 2, cur_q);
		e.fwd_sh = shoup_of(e.fwd_tw, cur_q);
		e.inv_sh = shoup_of(e.inv_tw, cur_q);
		e.n_inv_sh = shoup_of(e.n_inv, cur_q);
		return e;
	endfunction

	// driver: offer queued indexes, predict each accepted item
	always @(posedge clk or negedge arst_n) begin
		logic v;
		if (!arst_n) begin
			in_valid <= 1'b0;
			table_index <= '0;
			in_gap = 0;
		end else begin
			v = in_valid;
			if (in_valid && in_ready) begin
				entry_queue.push_back(twiddle_entry(table_index));
				v = 1'b0;
				in_gap = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (!v) begin
				if (in_gap > 0)
					in_gap--;
				else if (index_queue.size() > 0) begin
					v = 1'b1;
					table_index <= index_queue.pop_front();
				end
			end
			in_valid <= v;
		end
	end

	// monitor: check each accepted item, pace the ready line
	always @(posedge clk or negedge arst_n) begin
		entry_t e;
		logic r;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
			hold_left = 0;
		end else begin
			r = out_ready;
			if (out_valid && out_ready) begin
				if (entry_queue.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = entry_queue.pop_front();
					if (fwd_twiddle !== e.fwd_tw) begin
						$error("fwd_twiddle exp %h got %h", e.fwd_tw, fwd_twiddle);
						errors++;
					end
					if (fwd_shoup !== e.fwd_sh) begin
						$error("fwd_shoup exp %h got %h", e.fwd_sh, fwd_shoup);
						errors++;
					end
					if (inv_twiddle !== e.inv_tw) begin
						$error("inv_twiddle exp %h got %h", e.inv_tw, inv_twiddle);
						errors++;
					end
					if (inv_shoup !== e.inv_sh) begin
						$error("inv_shoup exp %h got %h", e.inv_sh, inv_shoup);
						errors++;
					end
					if (size_inverse !== e.n_inv) begin
						$error("size_inverse exp %h got %h", e.n_inv, size_inverse);
						errors++;
					end
					if (size_inverse_shoup !== e.n_inv_sh) begin
						$error("size_inverse_shoup exp %h got %h", e.n_inv_sh,
							size_inverse_shoup);
						errors++;
					end
					if (index_bad !== e.bad) begin
						$error("index_bad exp %b got %b", e.bad, index_bad);
						errors++;
					end
				end
				r = 1'b0;
				out_gap = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (hold_request && hold_left == 0)
				hold_left = HoldCycles;
			if (hold_left > 0) begin
				hold_left--;
				r = 1'b0;
			end else if (!r) begin
				if (out_gap > 0)
					out_gap--;
				else
					r = 1'b1;
			end
			out_ready <= r;
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [WordW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_tables(logic [WordW-1:0] q, logic [WordW-1:0] r, logic [WordW-1:0] ln);
		write_reg(RegModulus, q);
		write_reg(RegRoot, r);
		write_reg(RegLogN, ln);
		cur_q = q;
		cur_root = r;
		cur_log_n = ln[4:0];
	endtask

	// hold until every offered index has come back, then settle
	task automatic drain();
		while (index_queue.size() > 0 || in_valid || entry_queue.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned ln;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		hold_request = 1'b0;
		no_idle = 1'b0;
		quiet_cycles = 0;
		cur_q = 64'd3;
		cur_root = 64'd1;
		cur_log_n = 5'd0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: n is one, so only index zero is in range
		index_queue = '{16'd0, 16'd1, 16'hFFFF};
		drain();

		// largest 64-bit prime, full size
		set_tables(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAB0);
		index_queue = '{16'd0, 16'd1, 16'h8000, 16'hFFFF};
		drain();

		// degenerate moduli zero and one; receiver holds off a while
		set_tables(64'd0, 64'h5555_5555_5555_5555, 64'd2);
		hold_request = 1'b1;
		index_queue = '{16'd0, 16'd3, 16'd4};
		repeat (20) @(posedge clk);
		hold_request = 1'b0;
		drain();
		set_tables(64'd1, 64'd7, 64'd1);
		index_queue = '{16'd1, 16'd2};
		drain();

		// modulus two: both inverses come out as one
		set_tables(64'd2, 64'd1, 64'd1);
		index_queue = '{16'd0, 16'd1};
		drain();

		// n divisible by the modulus
		set_tables(64'd4, 64'd3, 64'd3);
		index_queue = '{16'd5, 16'd8};
		drain();

		// oversized log_n saturates to the full table
		set_tables(64'd65537, 64'd3, 64'd31);
		no_idle = 1'b1;
		index_queue = '{16'hFFFF, 16'h1234, 16'd0};
		drain();
		no_idle = 1'b0;

		// random settings, mostly in-range indexes
		for (int p = 0; p < 9; p++) begin
			ln = (p == 0) ? 16 : $urandom_range(0, 17);
			set_tables({$urandom, $urandom} | 64'd1, {$urandom, $urandom},
				{$urandom, 27'd0, 5'(ln)});
			ln = (ln > MaxLogN) ? MaxLogN : ln;
			no_idle = (p % 3 == 2);
			for (int k = 0; k < 9; k++) begin
				if ($urandom_range(0, 7) == 0)
					index_queue.push_back(16'($urandom));
				else
					index_queue.push_back(16'($urandom) & 16'((32'd1 << ln) - 1));
			end
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
